FILE: sv/vtesp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtesp_pkg : shared types and constants of the VT escape sequence parser
// Byte codes, event codes, byte class helpers and the job record that the
// front end hands to the back end through the job queue.
// ----------------------------------------------------------------------------
package vtesp_pkg;

    localparam int MaxParams  = 16;
    localparam int IdxW       = (MaxParams > 1) ? $clog2(MaxParams) : 1;
    localparam int CntW       = $clog2(MaxParams + 1);
    localparam int OscLimit   = 1048576;
    localparam int OscW       = $clog2(OscLimit + 1);
    localparam int ParamClamp = 100000;

    localparam logic [20:0] ReplChar = 21'h00FFFD;
    localparam logic [20:0] MaxCode  = 21'h10FFFF;
    localparam logic [20:0] SurLo    = 21'h00D800;
    localparam logic [20:0] SurHi    = 21'h00DFFF;

    // bytes with a meaning of their own
    localparam logic [7:0] BEsc   = 8'h1B;
    localparam logic [7:0] BCan   = 8'h18;
    localparam logic [7:0] BSub   = 8'h1A;
    localparam logic [7:0] BBel   = 8'h07;
    localparam logic [7:0] BTab   = 8'h09;
    localparam logic [7:0] BSt    = 8'h9C;
    localparam logic [7:0] BDel   = 8'h7F;
    localparam logic [7:0] BCsi   = 8'h5B;
    localparam logic [7:0] BOsc   = 8'h5D;
    localparam logic [7:0] BDcs   = 8'h50;
    localparam logic [7:0] BBsl   = 8'h5C;
    localparam logic [7:0] BSos   = 8'h58;
    localparam logic [7:0] BPm    = 8'h5E;
    localparam logic [7:0] BApc   = 8'h5F;
    localparam logic [7:0] BColon = 8'h3A;
    localparam logic [7:0] BSemi  = 8'h3B;

    // event codes
    localparam logic [3:0] EvPrint     = 4'd0;
    localparam logic [3:0] EvExec      = 4'd1;
    localparam logic [3:0] EvEsc       = 4'd2;
    localparam logic [3:0] EvCsi       = 4'd3;
    localparam logic [3:0] EvHook      = 4'd4;
    localparam logic [3:0] EvPut       = 4'd5;
    localparam logic [3:0] EvUnhook    = 4'd6;
    localparam logic [3:0] EvOscData   = 4'd7;
    localparam logic [3:0] EvOscEnd    = 4'd8;
    localparam logic [3:0] EvOscCancel = 4'd9;

    typedef struct packed {
        logic [3:0]  ev;
        logic [20:0] code;
        logic [5:0]  inter;
    } slot_t;

    // one job: up to two plain events, or one parameter run
    typedef struct packed {
        logic            run;
        logic [1:0]      n;
        slot_t [1:0]     slot;
        logic [5:0]      marker;
        logic [CntW-1:0] cnt;
    } job_t;

    function automatic logic is_ctl(logic [7:0] b);
        return (b <= 8'h17) || (b == 8'h19) || (b >= 8'h1C && b <= 8'h1F);
    endfunction

    function automatic logic is_inter(logic [7:0] b);
        return b >= 8'h20 && b <= 8'h2F;
    endfunction

    function automatic logic is_param(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h3F;
    endfunction

    function automatic logic is_marker(logic [7:0] b);
        return b >= 8'h3C && b <= 8'h3F;
    endfunction

    function automatic logic is_fin(logic [7:0] b);
        return b >= 8'h40 && b <= 8'h7E;
    endfunction

    function automatic logic is_esc_fin(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h7E;
    endfunction

    // append a plain event to a job
    function automatic job_t add_slot(job_t j, logic [3:0] ev, logic [20:0] code,
                                      logic [5:0] inter);
        job_t r;
        r = j;
        r.slot[j.n[0]].ev    = ev;
        r.slot[j.n[0]].code  = code;
        r.slot[j.n[0]].inter = inter;
        r.n = j.n + 2'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/vt_escape_sequence_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vt_escape_sequence_parser_unit : VT/ANSI escape sequence parser
// Byte in, terminal events out: print, execute, ESC, CSI, DCS and OSC.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the job queue is not full and no
// parameter run is being read out. A byte gives one event, none, or two (a
// replacement character plus the byte, or a cancel plus its follow-up). A
// CSI or DCS hook final byte gives max(1, parameter count) beats, one per
// cycle while the output is taken, read from the parameter table; input is
// held from the cycle after that byte until its last beat leaves the job
// queue. A two-entry job queue sits between the parser and the event
// emitter, and results leave through an output register, so while a result
// waits to be taken up to two further bytes that give events are still
// accepted; bytes giving no event keep flowing until the queue is full.
// ----------------------------------------------------------------------------
module vt_escape_sequence_parser_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [7:0]          data_byte,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [3:0]          event_res,
    output logic [20:0]         code,
    output logic [5:0]          intermediate_byte,
    output logic [5:0]          private_marker,
    output logic [4:0]          param_count,
    output logic [3:0]          param_index,
    output logic signed [20:0]  param_value,
    output logic [7:0]          sub_count,
    output logic                last
);

    logic               q_full;
    logic               push;
    vtesp_pkg::job_t    push_job;
    logic               head_valid;
    vtesp_pkg::job_t    head;
    logic               pop;
    logic               run_done;
    logic signed [20:0] pv [vtesp_pkg::MaxParams];
    logic [7:0]         sc [vtesp_pkg::MaxParams];

    vtesp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job),
        .run_done  (run_done),
        .pv        (pv),
        .sc        (sc)
    );

    vtesp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    vtesp_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (head_valid),
        .head              (head),
        .pop               (pop),
        .run_done          (run_done),
        .pv                (pv),
        .sc                (sc),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .event_res         (event_res),
        .code              (code),
        .intermediate_byte (intermediate_byte),
        .private_marker    (private_marker),
        .param_count       (param_count),
        .param_index       (param_index),
        .param_value       (param_value),
        .sub_count         (sub_count),
        .last              (last)
    );

endmodule
`default_nettype wire

FILE: sv/vtesp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtesp_front : byte classifier and parser state
// Accepts one byte per beat; runs the escape sequence state machine, parameter
// collector and UTF-8 decoder; pushes one job per byte that gives events.
// ----------------------------------------------------------------------------
module vtesp_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [7:0]                   data_byte,
    input  wire                          q_full,
    output logic                         push,
    output vtesp_pkg::job_t              job,
    input  wire                          run_done,
    output logic signed [20:0]           pv [vtesp_pkg::MaxParams],
    output logic [7:0]                   sc [vtesp_pkg::MaxParams]
);

    typedef enum logic [3:0] {
        PsGround, PsEsc, PsEscInt, PsCsiEntry, PsCsiParam, PsCsiInt, PsCsiIgn,
        PsDcsEntry, PsDcsParam, PsDcsInt, PsDcsPass, PsDcsIgn, PsStrIgn, PsOsc
    } ps_t;

    ps_t                         ps_reg, ps_next;
    logic [vtesp_pkg::CntW-1:0]  used_reg, used_next;
    logic                        open_reg, open_next;
    logic [5:0]                  inter_reg, inter_next;
    logic [5:0]                  marker_reg, marker_next;
    logic                        pend_reg, pend_next;
    logic [vtesp_pkg::OscW-1:0]  osc_reg, osc_next;
    logic [1:0]                  uleft_reg, uleft_next;
    logic [20:0]                 uacc_reg, uacc_next;
    logic [16:0]                 ufloor_reg, ufloor_next;
    logic signed [20:0]          cval_reg, cval_next;
    logic [7:0]                  csub_reg, csub_next;
    logic                        busy_reg;
    logic                        wr_en;
    logic                        accept;
    vtesp_pkg::job_t             job_c;

    assign in_ready = !q_full && !busy_reg;
    assign accept   = in_valid && in_ready;
    assign job      = job_c;
    assign push     = accept && (job_c.run || job_c.n != 2'd0);

    // classify the byte and work out the next parser state
    always_comb
    begin
        logic [7:0]  b;
        logic        go;
        logic        do_clear;
        logic        do_inter;
        logic        do_param;
        logic [20:0] cp;
        logic signed [20:0] v;
        b           = data_byte;
        go          = 1'b0;
        do_clear    = 1'b0;
        do_inter    = 1'b0;
        do_param    = 1'b0;
        cp          = '0;
        v           = '0;
        ps_next     = ps_reg;
        used_next   = used_reg;
        open_next   = open_reg;
        inter_next  = inter_reg;
        marker_next = marker_reg;
        pend_next   = pend_reg;
        osc_next    = osc_reg;
        uleft_next  = uleft_reg;
        uacc_next   = uacc_reg;
        ufloor_next = ufloor_reg;
        cval_next   = cval_reg;
        csub_next   = csub_reg;
        wr_en       = 1'b0;
        job_c       = '0;

        if (b == vtesp_pkg::BEsc)
        begin
            do_clear = 1'b1;
            if (ps_reg == PsDcsPass)
                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvUnhook, '0, '0);
            if (pend_reg)
                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvOscCancel, {13'd0, b}, '0);
            pend_next = (ps_reg == PsOsc);
            if (ps_reg != PsOsc)
                osc_next = '0;
            ps_next = PsEsc;
        end
        else if (b == vtesp_pkg::BCan || b == vtesp_pkg::BSub)
        begin
            if (ps_reg == PsDcsPass)
                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvUnhook, '0, '0);
            if (ps_reg == PsOsc || pend_reg)
                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvOscCancel, {13'd0, b}, '0);
            if (b == vtesp_pkg::BSub)
                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvPrint, vtesp_pkg::ReplChar,
                                            '0);
            pend_next = 1'b0;
            osc_next  = '0;
            ps_next   = PsGround;
        end
        else
        begin
            go = 1'b1;
            if (pend_reg)
            begin
                pend_next = 1'b0;
                osc_next  = '0;
                if (b == vtesp_pkg::BBsl)
                begin
                    ps_next = PsGround;
                    job_c   = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvOscEnd, {13'd0, b}, '0);
                    go      = 1'b0;
                end
                else
                begin
                    job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvOscCancel, {13'd0, b}, '0);
                end
            end
        end

        if (go)
        begin
            case (ps_reg)
                PsGround:
                begin
                    if (vtesp_pkg::is_ctl(b))
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvExec, {13'd0, b}, '0);
                    else
                    begin
                        go = 1'b1;
                        // continue or break a multi-byte sequence
                        if (uleft_reg != 2'd0)
                        begin
                            if (b[7:6] == 2'b10)
                            begin
                                go         = 1'b0;
                                cp         = {uacc_reg[14:0], b[5:0]};
                                uleft_next = uleft_reg - 2'd1;
                                uacc_next  = cp;
                                if (uleft_reg == 2'd1)
                                begin
                                    uacc_next = '0;
                                    if (cp < {4'd0, ufloor_reg} ||
                                        (cp >= vtesp_pkg::SurLo && cp <= vtesp_pkg::SurHi) ||
                                        cp > vtesp_pkg::MaxCode)
                                        cp = vtesp_pkg::ReplChar;
                                    job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvPrint, cp,
                                                                '0);
                                end
                            end
                            else
                            begin
                                uleft_next = 2'd0;
                                uacc_next  = '0;
                                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvPrint,
                                                            vtesp_pkg::ReplChar, '0);
                            end
                        end
                        // decode the byte afresh
                        if (go)
                        begin
                            if (b[7] == 1'b0)
                                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvPrint,
                                                            {13'd0, b}, '0);
                            else if (b[7:5] == 3'b110)
                            begin
                                uacc_next   = {16'd0, b[4:0]};
                                uleft_next  = 2'd1;
                                ufloor_next = 17'h00080;
                            end
                            else if (b[7:4] == 4'b1110)
                            begin
                                uacc_next   = {17'd0, b[3:0]};
                                uleft_next  = 2'd2;
                                ufloor_next = 17'h00800;
                            end
                            else if (b[7:3] == 5'b11110)
                            begin
                                uacc_next   = {18'd0, b[2:0]};
                                uleft_next  = 2'd3;
                                ufloor_next = 17'h10000;
                            end
                            else
                                job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvPrint,
                                                            vtesp_pkg::ReplChar, '0);
                        end
                    end
                end
                PsEsc:
                begin
                    if (vtesp_pkg::is_ctl(b))
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvExec, {13'd0, b}, '0);
                    else if (vtesp_pkg::is_inter(b))
                    begin
                        do_inter = 1'b1;
                        ps_next  = PsEscInt;
                    end
                    else if (b == vtesp_pkg::BCsi)
                    begin
                        do_clear = 1'b1;
                        ps_next  = PsCsiEntry;
                    end
                    else if (b == vtesp_pkg::BOsc)
                    begin
                        osc_next = '0;
                        ps_next  = PsOsc;
                    end
                    else if (b == vtesp_pkg::BDcs)
                    begin
                        do_clear = 1'b1;
                        ps_next  = PsDcsEntry;
                    end
                    else if (b == vtesp_pkg::BSos || b == vtesp_pkg::BPm ||
                             b == vtesp_pkg::BApc)
                        ps_next = PsStrIgn;
                    else if (vtesp_pkg::is_esc_fin(b))
                    begin
                        job_c   = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvEsc, {13'd0, b}, '0);
                        ps_next = PsGround;
                    end
                end
                PsEscInt:
                begin
                    if (vtesp_pkg::is_ctl(b))
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvExec, {13'd0, b}, '0);
                    else if (vtesp_pkg::is_inter(b))
                        do_inter = 1'b1;
                    else if (vtesp_pkg::is_esc_fin(b))
                    begin
                        job_c   = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvEsc, {13'd0, b},
                                                      inter_reg);
                        ps_next = PsGround;
                    end
                end
                PsCsiEntry, PsCsiParam:
                begin
                    if (vtesp_pkg::is_ctl(b))
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvExec, {13'd0, b}, '0);
                    else if (vtesp_pkg::is_marker(b))
                    begin
                        if (ps_reg == PsCsiEntry)
                        begin
                            marker_next = b[5:0];
                            ps_next     = PsCsiParam;
                        end
                        else
                            ps_next = PsCsiIgn;
                    end
                    else if (vtesp_pkg::is_param(b))
                    begin
                        do_param = 1'b1;
                        ps_next  = PsCsiParam;
                    end
                    else if (vtesp_pkg::is_inter(b))
                    begin
                        do_inter = 1'b1;
                        ps_next  = PsCsiInt;
                    end
                    else if (vtesp_pkg::is_fin(b))
                    begin
                        job_c.run  = 1'b1;
                        job_c.slot[0] = '{ev: vtesp_pkg::EvCsi, code: {13'd0, b},
                                          inter: inter_reg};
                        ps_next    = PsGround;
                    end
                    else
                        ps_next = PsCsiIgn;
                end
                PsCsiInt:
                begin
                    if (vtesp_pkg::is_ctl(b))
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvExec, {13'd0, b}, '0);
                    else if (vtesp_pkg::is_inter(b))
                        do_inter = 1'b1;
                    else if (vtesp_pkg::is_param(b))
                        ps_next = PsCsiIgn;
                    else if (vtesp_pkg::is_fin(b))
                    begin
                        job_c.run  = 1'b1;
                        job_c.slot[0] = '{ev: vtesp_pkg::EvCsi, code: {13'd0, b},
                                          inter: inter_reg};
                        ps_next    = PsGround;
                    end
                end
                PsCsiIgn:
                begin
                    if (vtesp_pkg::is_ctl(b))
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvExec, {13'd0, b}, '0);
                    else if (vtesp_pkg::is_fin(b))
                        ps_next = PsGround;
                end
                PsDcsEntry, PsDcsParam, PsDcsInt:
                begin
                    if (ps_reg == PsDcsEntry && vtesp_pkg::is_marker(b))
                    begin
                        marker_next = b[5:0];
                        ps_next     = PsDcsParam;
                    end
                    else if (ps_reg != PsDcsInt && vtesp_pkg::is_param(b) &&
                             !vtesp_pkg::is_marker(b))
                    begin
                        do_param = 1'b1;
                        ps_next  = PsDcsParam;
                    end
                    else if (vtesp_pkg::is_inter(b))
                    begin
                        do_inter = 1'b1;
                        ps_next  = PsDcsInt;
                    end
                    else if (vtesp_pkg::is_fin(b))
                    begin
                        job_c.run  = 1'b1;
                        job_c.slot[0] = '{ev: vtesp_pkg::EvHook, code: {13'd0, b},
                                          inter: inter_reg};
                        ps_next    = PsDcsPass;
                    end
                    else
                        ps_next = PsDcsIgn;
                end
                PsDcsPass:
                begin
                    if (b == vtesp_pkg::BSt)
                    begin
                        job_c   = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvUnhook, '0, '0);
                        ps_next = PsGround;
                    end
                    else if (b != vtesp_pkg::BDel)
                        job_c = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvPut, {13'd0, b}, '0);
                end
                PsOsc:
                begin
                    if (b == vtesp_pkg::BBel || b == vtesp_pkg::BSt)
                    begin
                        job_c    = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvOscEnd, {13'd0, b},
                                                       '0);
                        osc_next = '0;
                        ps_next  = PsGround;
                    end
                    else if ((b >= 8'h20 || b == vtesp_pkg::BTab) &&
                             osc_reg < vtesp_pkg::OscW'(vtesp_pkg::OscLimit))
                    begin
                        job_c    = vtesp_pkg::add_slot(job_c, vtesp_pkg::EvOscData,
                                                       {13'd0, b}, '0);
                        osc_next = osc_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (b == vtesp_pkg::BSt)
                        ps_next = PsGround;
                end
            endcase
        end

        // the run carries marker and count as they stand now
        job_c.marker = marker_reg;
        job_c.cnt    = used_reg;

        // drop the sequence collected so far
        if (do_clear)
        begin
            used_next   = '0;
            open_next   = 1'b0;
            inter_next  = '0;
            marker_next = '0;
        end

        // keep the first intermediate byte only
        if (do_inter && inter_reg == 6'd0)
            inter_next = b[5:0];

        // collect a parameter digit or separator
        if (do_param)
        begin
            if (b == vtesp_pkg::BSemi || b == vtesp_pkg::BColon)
            begin
                if (!open_reg && used_reg < vtesp_pkg::CntW'(vtesp_pkg::MaxParams))
                begin
                    cval_next = -21'sd1;
                    csub_next = '0;
                    used_next = used_reg + 1'b1;
                end
                if (b == vtesp_pkg::BColon && used_next != '0 && csub_next != 8'd255)
                    csub_next = csub_next + 8'd1;
                open_next = 1'b0;
                wr_en     = (used_next != '0);
            end
            else if (b <= 8'h39 && used_reg < vtesp_pkg::CntW'(vtesp_pkg::MaxParams))
            begin
                v = cval_reg;
                if (!open_reg)
                begin
                    v         = '0;
                    csub_next = '0;
                    used_next = used_reg + 1'b1;
                    open_next = 1'b1;
                end
                if (v < 0)
                    v = '0;
                if (v < 21'(vtesp_pkg::ParamClamp))
                    v = (v <<< 3) + (v <<< 1) + $signed({17'd0, b[3:0]});
                cval_next = v;
                wr_en     = 1'b1;
            end
        end
    end

    // hold the parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg     <= PsGround;
            used_reg   <= '0;
            open_reg   <= 1'b0;
            inter_reg  <= '0;
            marker_reg <= '0;
            pend_reg   <= 1'b0;
            osc_reg    <= '0;
            uleft_reg  <= '0;
            uacc_reg   <= '0;
            ufloor_reg <= '0;
            cval_reg   <= '0;
            csub_reg   <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ps_reg     <= ps_next;
                used_reg   <= used_next;
                open_reg   <= open_next;
                inter_reg  <= inter_next;
                marker_reg <= marker_next;
                pend_reg   <= pend_next;
                osc_reg    <= osc_next;
                uleft_reg  <= uleft_next;
                uacc_reg   <= uacc_next;
                ufloor_reg <= ufloor_next;
                cval_reg   <= cval_next;
                csub_reg   <= csub_next;
            end
            // hold input while the parameter table is being read out
            if (accept && job_c.run)
                busy_reg <= 1'b1;
            else if (run_done)
                busy_reg <= 1'b0;
        end
    end

    // write the open parameter back to its slot
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            pv[used_next[vtesp_pkg::IdxW-1:0] - 1'b1] <= cval_next;
            sc[used_next[vtesp_pkg::IdxW-1:0] - 1'b1] <= csub_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/vtesp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtesp_queue : two-entry job queue
// Parts the front end from the back end so that each side stalls on its own.
// ----------------------------------------------------------------------------
module vtesp_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  vtesp_pkg::job_t  push_job,
    output logic             full,
    output logic             head_valid,
    output vtesp_pkg::job_t  head,
    input  wire              pop
);

    vtesp_pkg::job_t mem_reg [2];
    logic            wp_reg;
    logic            rp_reg;
    logic [1:0]      cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rp_reg];

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

endmodule
`default_nettype wire

FILE: sv/vtesp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtesp_back : event emitter
// Expands the job at the queue head into result beats, one per cycle while
// the output register is free; runs read the parameter table slot by slot.
// ----------------------------------------------------------------------------
module vtesp_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         head_valid,
    input  vtesp_pkg::job_t             head,
    output logic                        pop,
    output logic                        run_done,
    input  wire signed [20:0]           pv [vtesp_pkg::MaxParams],
    input  wire  [7:0]                  sc [vtesp_pkg::MaxParams],
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [3:0]                  event_res,
    output logic [20:0]                 code,
    output logic [5:0]                  intermediate_byte,
    output logic [5:0]                  private_marker,
    output logic [4:0]                  param_count,
    output logic [3:0]                  param_index,
    output logic signed [20:0]          param_value,
    output logic [7:0]                  sub_count,
    output logic                        last
);

    logic [vtesp_pkg::IdxW-1:0] k_reg;
    logic                       out_valid_reg;
    logic                       out_free;
    logic                       beat_last;
    vtesp_pkg::slot_t           sl;

    assign out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sl = head.run ? head.slot[0] : head.slot[k_reg[0]];

    // find the final beat of the head job
    always_comb
    begin
        if (head.run)
            beat_last = (head.cnt == '0) ||
                        ({1'b0, k_reg} == head.cnt - vtesp_pkg::CntW'(1));
        else
            beat_last = (2'(k_reg[0]) == head.n - 2'd1);
    end

    assign pop      = out_free && head_valid && beat_last;
    assign run_done = pop && head.run;

    // advance the beat counter and valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
            begin
                if (beat_last)
                    k_reg <= '0;
                else
                    k_reg <= k_reg + 1'b1;
            end
        end
    end

    // load the output beat
    always_ff @(posedge clk)
    begin
        if (out_free && head_valid)
        begin
            event_res         <= sl.ev;
            code              <= sl.code;
            intermediate_byte <= sl.inter;
            last              <= beat_last;
            if (head.run && head.cnt != '0)
            begin
                private_marker <= head.marker;
                param_count    <= 5'(head.cnt);
                param_index    <= 4'(k_reg);
                param_value    <= pv[k_reg];
                sub_count      <= sc[k_reg];
            end
            else
            begin
                private_marker <= head.run ? head.marker : 6'd0;
                param_count    <= '0;
                param_index    <= '0;
                param_value    <= '0;
                sub_count      <= '0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/vtesp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtesp_checker : port-level checks of the escape sequence parser
// Watches the result channel and checks event coding and parameter fields.
// ----------------------------------------------------------------------------
module vtesp_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 out_valid,
    input wire                 out_ready,
    input wire [3:0]           event_res,
    input wire [4:0]           param_count,
    input wire [3:0]           param_index,
    input wire signed [20:0]   param_value,
    input wire [7:0]           sub_count
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // only known event codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= vtesp_pkg::EvOscCancel)
        else $error("unknown event code");

    // parameter fields stay clear outside runs
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != vtesp_pkg::EvCsi && event_res != vtesp_pkg::EvHook |->
        param_count == 5'd0 && param_value == 21'sd0 && sub_count == 8'd0)
        else $error("parameter field set on a plain event");

    // index inside the run and value within its clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && param_count != 5'd0 |->
        {1'b0, param_index} < param_count && param_value >= -21'sd1 &&
        param_value <= 21'sd999999)
        else $error("parameter run out of range");

endmodule

bind vt_escape_sequence_parser_unit vtesp_checker u_chk (.*);
`default_nettype wire
